/* src/iac_pkg.sv */
// ----------------------------------------------------------------------------
// Intruder alarm controller package
// Shared types and constants for the alarm controller and its step logic.
// ----------------------------------------------------------------------------
`default_nettype none

package iac_pkg;

    localparam int MODE_W  = 3;
    localparam int TONE_W  = 2;
    localparam int KEY_W   = 4;
    localparam int CFG_W   = 16;
    localparam int CODE_W  = 12;
    localparam int CIDX_W  = 3;

    localparam logic [MODE_W-1:0] MODE_OFF     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ON      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ALARM   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_STANDBY = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TIME    = 3'd4;

    localparam logic [TONE_W-1:0] TONE_SILENT = 2'd0;
    localparam logic [TONE_W-1:0] TONE_LOW    = 2'd1;
    localparam logic [TONE_W-1:0] TONE_HIGH   = 2'd2;

    localparam logic [KEY_W-1:0] KEY_STAR = 4'd12;

    localparam logic [CIDX_W-1:0] REG_EXIT_DELAY  = 3'd0;
    localparam logic [CIDX_W-1:0] REG_ACCESS_CODE = 3'd1;
    localparam logic [CIDX_W-1:0] REG_LED_TOGGLE  = 3'd2;
    localparam logic [CIDX_W-1:0] REG_BEEP_PERIOD = 3'd3;
    localparam logic [CIDX_W-1:0] REG_BEEP_ON     = 3'd4;

    localparam logic [CFG_W-1:0]  EXIT_DELAY_RST  = 16'd3000;
    localparam logic [CODE_W-1:0] ACCESS_CODE_RST = 12'h555;
    localparam logic [CFG_W-1:0]  LED_TOGGLE_RST  = 16'd300;
    localparam logic [CFG_W-1:0]  BEEP_PERIOD_RST = 16'd1000;
    localparam logic [CFG_W-1:0]  BEEP_ON_RST     = 16'd250;

    typedef struct packed {
        logic [CFG_W-1:0]  exit_delay_ticks;
        logic [CODE_W-1:0] access_code;
        logic [CFG_W-1:0]  led_toggle_ticks;
        logic [CFG_W-1:0]  beep_period_ticks;
        logic [CFG_W-1:0]  beep_on_ticks;
    } cfg_t;

    typedef struct packed {
        logic             tick;
        logic             motion;
        logic             key_valid;
        logic [KEY_W-1:0] key_index;
    } item_t;

    typedef struct packed {
        logic [MODE_W-1:0] alarm_mode;
        logic              led_on;
        logic [TONE_W-1:0] tone_code;
    } result_t;

endpackage

`default_nettype wire

/* src/iac_core.sv */
// ----------------------------------------------------------------------------
// Alarm controller step logic
// Holds the mode, delay, code entry, LED and beep state and advances it by
// one request whenever step_en is high.
// ----------------------------------------------------------------------------
`default_nettype none

module iac_core
    import iac_pkg::*;
#(
    parameter int CODE_DIGITS = 3,
    parameter int COUNT_WIDTH = 16
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    step_en,
    input  wire item_t   item,
    input  wire cfg_t    cfg,
    output result_t      result_next
);

    localparam int CODE_BITS = 4 * CODE_DIGITS;
    localparam int DCNT_W    = $clog2(CODE_DIGITS + 1);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        logic [COUNT_WIDTH-1:0] r;
        r = (v == CNT_MAX) ? v : v + 1'b1;
        return r;
    endfunction

    logic [MODE_W-1:0]      mode_reg, mode_next;
    logic                   run_reg, run_next;
    logic [COUNT_WIDTH-1:0] dcnt_reg, dcnt_next;
    logic [CODE_BITS-1:0]   buf_reg, buf_next;
    logic [DCNT_W-1:0]      digits_reg, digits_next;
    logic                   led_reg, led_next;
    logic [COUNT_WIDTH-1:0] lcnt_reg, lcnt_next;
    logic [COUNT_WIDTH-1:0] bcnt_reg, bcnt_next;

    logic [COUNT_WIDTH-1:0] bcnt_inc;
    logic [CODE_BITS-1:0]   code_ext;
    logic [31:0]            code_wide;

    // The access code register is sized for three digits; other digit counts
    // truncate or zero-extend it.
    assign code_wide = 32'(cfg.access_code);
    assign code_ext  = code_wide[CODE_BITS-1:0];
    assign bcnt_inc  = sat_inc(bcnt_reg);

    always_comb
    begin
        mode_next   = mode_reg;
        run_next    = run_reg;
        dcnt_next   = dcnt_reg;
        buf_next    = buf_reg;
        digits_next = digits_reg;
        led_next    = led_reg;
        lcnt_next   = lcnt_reg;
        bcnt_next   = bcnt_reg;

        if (mode_next == MODE_ON && item.motion)
        begin
            mode_next = MODE_TIME;
            run_next  = 1'b1;
            dcnt_next = '0;
        end

        if (item.tick && run_next)
        begin
            dcnt_next = sat_inc(dcnt_next);
            if (32'(dcnt_next) > 32'(cfg.exit_delay_ticks))
            begin
                if (mode_next == MODE_STANDBY)
                    mode_next = MODE_ON;
                else if (mode_next == MODE_TIME)
                    mode_next = MODE_ALARM;
            end
        end

        if (item.key_valid)
        begin
            if (item.key_index == KEY_STAR)
            begin
                mode_next = MODE_STANDBY;
                run_next  = 1'b1;
                dcnt_next = '0;
            end
            else
            begin
                buf_next    = CODE_BITS'({buf_reg, item.key_index});
                digits_next = digits_reg + 1'b1;
                if (digits_next >= DCNT_W'(CODE_DIGITS))
                begin
                    if (buf_next == code_ext)
                    begin
                        mode_next = MODE_OFF;
                        run_next  = 1'b0;
                        dcnt_next = '0;
                    end
                    buf_next    = '0;
                    digits_next = '0;
                end
            end
        end

        if (item.tick)
        begin
            lcnt_next = sat_inc(lcnt_reg);
            if (32'(lcnt_next) >= 32'(cfg.led_toggle_ticks))
            begin
                lcnt_next = '0;
                if (mode_next == MODE_OFF)
                    led_next = 1'b0;
                else if (mode_next == MODE_ON)
                    led_next = 1'b1;
                else
                    led_next = !led_reg;
            end
            bcnt_next = (32'(bcnt_inc) >= 32'(cfg.beep_period_ticks)) ? '0 : bcnt_inc;
        end

        result_next.alarm_mode = mode_next;
        result_next.led_on     = led_next;
        if (mode_next == MODE_ALARM)
            result_next.tone_code = TONE_HIGH;
        else if ((mode_next == MODE_STANDBY || mode_next == MODE_TIME) &&
                 32'(bcnt_next) < 32'(cfg.beep_on_ticks))
            result_next.tone_code = TONE_LOW;
        else
            result_next.tone_code = TONE_SILENT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_OFF;
            run_reg    <= 1'b0;
            dcnt_reg   <= '0;
            buf_reg    <= '0;
            digits_reg <= '0;
            led_reg    <= 1'b0;
            lcnt_reg   <= '0;
            bcnt_reg   <= '0;
        end
        else if (step_en)
        begin
            mode_reg   <= mode_next;
            run_reg    <= run_next;
            dcnt_reg   <= dcnt_next;
            buf_reg    <= buf_next;
            digits_reg <= digits_next;
            led_reg    <= led_next;
            lcnt_reg   <= lcnt_next;
            bcnt_reg   <= bcnt_next;
        end
    end

endmodule

`default_nettype wire

/* src/intruder_alarm_controller_unit.sv */
// Path: a request passes through the input register, then the result
// register; it waits in the input register while the output stalls.
// Throughput: one request per cycle; the step logic updates all state for
// each request, so only output backpressure slows acceptance.
// Reset: asynchronous, active low; the mode goes to off, all counters clear
// and the configuration registers return to their default values.
// ----------------------------------------------------------------------------
// Intruder alarm controller
// Burglar alarm with exit and entry delay, keypad code entry, blinking LED
// and warning tones, at most one millisecond tick per request.
// ----------------------------------------------------------------------------
`default_nettype none

module intruder_alarm_controller_unit
    import iac_pkg::*;
#(
    parameter int CODE_DIGITS = 3,
    parameter int COUNT_WIDTH = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write_en,
    input  wire logic [CIDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              tick,
    input  wire logic              motion,
    input  wire logic              key_valid,
    input  wire logic [KEY_W-1:0]  key_index,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [MODE_W-1:0]      alarm_mode,
    output logic                   led_on,
    output logic [TONE_W-1:0]      tone_code
);

    cfg_t    cfg_reg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t result_reg;
    result_t result_next;
    logic    step_en;

    // The registered request moves on when the result register is free or
    // being emptied in the same cycle.
    assign step_en  = item_valid_reg && (!out_valid || out_ready);
    assign in_ready = !item_valid_reg || step_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.exit_delay_ticks  <= EXIT_DELAY_RST;
            cfg_reg.access_code       <= ACCESS_CODE_RST;
            cfg_reg.led_toggle_ticks  <= LED_TOGGLE_RST;
            cfg_reg.beep_period_ticks <= BEEP_PERIOD_RST;
            cfg_reg.beep_on_ticks     <= BEEP_ON_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_EXIT_DELAY:  cfg_reg.exit_delay_ticks  <= cfg_data;
                REG_ACCESS_CODE: cfg_reg.access_code       <= cfg_data[CODE_W-1:0];
                REG_LED_TOGGLE:  cfg_reg.led_toggle_ticks  <= cfg_data;
                REG_BEEP_PERIOD: cfg_reg.beep_period_ticks <= cfg_data;
                REG_BEEP_ON:     cfg_reg.beep_on_ticks     <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid      <= 1'b0;
        end
        else
        begin
            if (in_ready)
                item_valid_reg <= in_valid;
            if (step_en)
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.tick      <= tick;
            item_reg.motion    <= motion;
            item_reg.key_valid <= key_valid;
            item_reg.key_index <= key_index;
        end
        if (step_en)
            result_reg <= result_next;
    end

    iac_core #(
        .CODE_DIGITS (CODE_DIGITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (step_en),
        .item        (item_reg),
        .cfg         (cfg_reg),
        .result_next (result_next)
    );

    assign alarm_mode = result_reg.alarm_mode;
    assign led_on     = result_reg.led_on;
    assign tone_code  = result_reg.tone_code;

endmodule

`default_nettype wire
